>>> design/gbc_pkg.sv
// Package for the GOST 28147-89 ECB cipher: the word type handed between round cells,
// register indexes, the S-box sets and the round function.
// No dependencies.
`default_nettype none

package gbc_pkg;

	localparam int unsigned CFG_INDEX_W = 8;
	localparam int unsigned CFG_DATA_W  = 64;
	localparam int unsigned NUM_ROUNDS  = 32;
	localparam int unsigned NUM_KEY_REGS = 4;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_01 = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_23 = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_45 = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_67 = 8'd3;

	// Operation codes of the func field.
	localparam logic FUNC_ENCRYPT = 1'b0;
	localparam logic FUNC_DECRYPT = 1'b1;

	typedef logic [3:0] nib_t;

	// Word passed from one round cell to the next. Half a is the one that
	// enters the round function; half b is the one that takes the XOR.
	typedef struct packed {
		logic        dec;
		logic [31:0] a;
		logic [31:0] b;
	} gbc_word_t;

	localparam nib_t SBOX_SETS [0:2][0:7][0:15] = '{
		'{
			'{4'd4,  4'd10, 4'd9,  4'd2,  4'd13, 4'd8,  4'd0,  4'd14,
			  4'd6,  4'd11, 4'd1,  4'd12, 4'd7,  4'd15, 4'd5,  4'd3},
			'{4'd14, 4'd11, 4'd4,  4'd12, 4'd6,  4'd13, 4'd15, 4'd10,
			  4'd2,  4'd3,  4'd8,  4'd1,  4'd0,  4'd7,  4'd5,  4'd9},
			'{4'd5,  4'd8,  4'd1,  4'd13, 4'd10, 4'd3,  4'd4,  4'd2,
			  4'd14, 4'd15, 4'd12, 4'd7,  4'd6,  4'd0,  4'd9,  4'd11},
			'{4'd7,  4'd13, 4'd10, 4'd1,  4'd0,  4'd8,  4'd9,  4'd15,
			  4'd14, 4'd4,  4'd6,  4'd12, 4'd11, 4'd2,  4'd5,  4'd3},
			'{4'd6,  4'd12, 4'd7,  4'd1,  4'd5,  4'd15, 4'd13, 4'd8,
			  4'd4,  4'd10, 4'd9,  4'd14, 4'd0,  4'd3,  4'd11, 4'd2},
			'{4'd4,  4'd11, 4'd10, 4'd0,  4'd7,  4'd2,  4'd1,  4'd13,
			  4'd3,  4'd6,  4'd8,  4'd5,  4'd9,  4'd12, 4'd15, 4'd14},
			'{4'd13, 4'd11, 4'd4,  4'd1,  4'd3,  4'd15, 4'd5,  4'd9,
			  4'd0,  4'd10, 4'd14, 4'd7,  4'd6,  4'd8,  4'd2,  4'd12},
			'{4'd1,  4'd15, 4'd13, 4'd0,  4'd5,  4'd7,  4'd10, 4'd4,
			  4'd9,  4'd2,  4'd3,  4'd14, 4'd6,  4'd11, 4'd8,  4'd12}
		},
		'{
			'{4'd11, 4'd10, 4'd15, 4'd5,  4'd0,  4'd12, 4'd14, 4'd8,
			  4'd6,  4'd2,  4'd3,  4'd9,  4'd1,  4'd7,  4'd13, 4'd4},
			'{4'd1,  4'd13, 4'd2,  4'd9,  4'd7,  4'd10, 4'd6,  4'd0,
			  4'd8,  4'd12, 4'd4,  4'd5,  4'd15, 4'd3,  4'd11, 4'd14},
			'{4'd3,  4'd10, 4'd13, 4'd12, 4'd1,  4'd2,  4'd0,  4'd11,
			  4'd7,  4'd5,  4'd9,  4'd4,  4'd8,  4'd15, 4'd14, 4'd6},
			'{4'd11, 4'd5,  4'd1,  4'd9,  4'd8,  4'd13, 4'd15, 4'd0,
			  4'd14, 4'd4,  4'd2,  4'd3,  4'd12, 4'd7,  4'd10, 4'd6},
			'{4'd14, 4'd7,  4'd10, 4'd12, 4'd13, 4'd1,  4'd3,  4'd9,
			  4'd0,  4'd2,  4'd11, 4'd4,  4'd15, 4'd8,  4'd5,  4'd6},
			'{4'd14, 4'd4,  4'd6,  4'd2,  4'd11, 4'd3,  4'd13, 4'd8,
			  4'd12, 4'd15, 4'd5,  4'd10, 4'd0,  4'd7,  4'd1,  4'd9},
			'{4'd3,  4'd7,  4'd14, 4'd9,  4'd8,  4'd10, 4'd15, 4'd0,
			  4'd5,  4'd2,  4'd6,  4'd12, 4'd11, 4'd4,  4'd13, 4'd1},
			'{4'd9,  4'd6,  4'd3,  4'd2,  4'd8,  4'd11, 4'd1,  4'd7,
			  4'd10, 4'd4,  4'd14, 4'd15, 4'd12, 4'd0,  4'd13, 4'd5}
		},
		'{
			'{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
			  4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
			'{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
			  4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
			'{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
			  4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
			'{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
			  4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
			'{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
			  4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
			'{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
			  4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
			'{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
			  4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
			'{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
			  4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
		}
	};

	// Eight S-box lookups followed by a rotate left by 11. The unused set
	// code falls back to the first set.
	function automatic logic [31:0] gbc_round_f(input logic [1:0] sel, input logic [31:0] x);
		logic [1:0]  set;
		logic [31:0] y;
		set = (sel == 2'd3) ? 2'd0 : sel;
		y   = '0;
		for (int n = 0; n < 8; n++) begin
			y[4*n +: 4] = SBOX_SETS[set][n][x[4*n +: 4]];
		end
		return {y[20:0], y[31:21]};
	endfunction

endpackage

`default_nettype wire

>>> design/gbc_chan_if.sv
// Channel interfaces of the GOST 28147-89 ECB cipher: one for blocks going in,
// one for transformed blocks coming out. Depends on nothing.
`default_nettype none

interface gbc_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [63:0] in_block;

	modport source (output valid, output func, output in_block, input ready);
	modport sink   (input valid, input func, input in_block, output ready);
endinterface

interface gbc_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_block;

	modport source (output valid, output out_block, input ready);
	modport sink   (input valid, input out_block, output ready);
endinterface

`default_nettype wire

>>> design/gbc_round_cell.sv
// One Feistel round of the cipher with its own register and handshake.
// Depends on gbc_pkg.
`default_nettype none

module gbc_round_cell #(
	parameter logic [1:0] SBOX_SET = 2'd0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              up_valid,
	output      logic              up_ready,
	input  wire gbc_pkg::gbc_word_t up_word,
	input  wire logic [31:0]       key_enc,
	input  wire logic [31:0]       key_dec,
	output      logic              down_valid,
	input  wire logic              down_ready,
	output      gbc_pkg::gbc_word_t down_word
);
	import gbc_pkg::*;

	logic        valid_q;
	gbc_word_t   word_q;
	logic [31:0] key;
	logic [31:0] sum;
	gbc_word_t   next_word;

	// The cell can take a word when it is empty or its own word leaves now.
	assign up_ready = !valid_q || down_ready;

	always_comb begin
		key = (up_word.dec == FUNC_DECRYPT) ? key_dec : key_enc;
		sum = up_word.a + key;
		// The halves swap on the way out, so every cell does the same job.
		next_word.dec = up_word.dec;
		next_word.a   = up_word.b ^ gbc_round_f(SBOX_SET, sum);
		next_word.b   = up_word.a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			word_q <= next_word;
		end
	end

	assign down_valid = valid_q;
	assign down_word  = word_q;

endmodule

`default_nettype wire

>>> design/gost_block_cipher_ecb.sv
// Top level of the GOST 28147-89 block cipher in electronic codebook mode.
// Depends on gbc_pkg, gbc_chan_if and gbc_round_cell.
//
// Usage:
// Blocks enter on data_chan (valid/ready, fields func and in_block) and leave
// on result_chan (valid/ready, field out_block), one result word per input word,
// in order. The key is loaded through the write port: cfg_we, cfg_index and
// cfg_data write one 64-bit key register per cycle; indexes past the fourth
// are ignored. Write the key only while no block is in flight.
// The datapath is a row of 32 round cells, one per Feistel round, each with
// its own register. An accepted block passes through the cell registers in
// order to result_chan. One new block can be accepted every cycle unless the
// row is full and stalled, so throughput is one block per clock when unstalled.
// Each cell holds its word until the next cell takes it, so when the receiver
// stalls the row fills from the output end, and data_chan.ready drops only
// once all 32 cells hold words. Empty cells keep accepting while a finished
// result waits.
// Reset empties every cell and clears the key registers to zero.
`default_nettype none

module gost_block_cipher_ecb #(
	parameter int unsigned SBOX_SELECT = 0
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	gbc_in_if.sink                                data_chan,
	gbc_out_if.source                             result_chan,
	input  wire logic                             cfg_we,
	input  wire logic [gbc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [gbc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import gbc_pkg::*;

	localparam logic [1:0] SBOX_SET = (SBOX_SELECT < 3) ? 2'(SBOX_SELECT) : 2'd0;

	logic [CFG_DATA_W-1:0] key_q [NUM_KEY_REGS];
	logic [31:0]           key_word [8];

	logic      chain_valid [NUM_ROUNDS+1];
	logic      chain_ready [NUM_ROUNDS+1];
	gbc_word_t chain_word  [NUM_ROUNDS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_KEY_REGS; i++) begin
				key_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_01: key_q[0] <= cfg_data;
				REG_KEY_23: key_q[1] <= cfg_data;
				REG_KEY_45: key_q[2] <= cfg_data;
				REG_KEY_67: key_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			key_word[k] = key_q[k/2][32*(k%2) +: 32];
		end
	end

	assign chain_valid[0]    = data_chan.valid;
	assign data_chan.ready   = chain_ready[0];
	assign chain_word[0].dec = data_chan.func;
	assign chain_word[0].a   = data_chan.in_block[31:0];
	assign chain_word[0].b   = data_chan.in_block[63:32];

	for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
		// Encryption runs the key forwards for 24 rounds, decryption for 8.
		localparam int KEY_ENC = (r < 24) ? (r % 8) : (7 - (r % 8));
		localparam int KEY_DEC = (r < 8)  ? (r % 8) : (7 - (r % 8));

		gbc_round_cell #(
			.SBOX_SET (SBOX_SET)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.up_valid   (chain_valid[r]),
			.up_ready   (chain_ready[r]),
			.up_word    (chain_word[r]),
			.key_enc    (key_word[KEY_ENC]),
			.key_dec    (key_word[KEY_DEC]),
			.down_valid (chain_valid[r+1]),
			.down_ready (chain_ready[r+1]),
			.down_word  (chain_word[r+1])
		);
	end

	assign chain_ready[NUM_ROUNDS] = result_chan.ready;
	assign result_chan.valid       = chain_valid[NUM_ROUNDS];
	// After the last round half a holds N1 and half b holds N2.
	assign result_chan.out_block   = {chain_word[NUM_ROUNDS].a, chain_word[NUM_ROUNDS].b};

endmodule

`default_nettype wire

>>> design/gbc_checker.sv
// Port-level checks for the GOST 28147-89 ECB cipher, bound to its top level.
// Depends on gost_block_cipher_ecb.
`default_nettype none

module gbc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [63:0] res_block
);

	// A stalled result word stays put until it is taken.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_block))
		else $error("result word changed while stalled");

	// With the receiver ready the whole row moves, so input is never refused.
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		res_ready |-> in_ready)
		else $error("input refused while the receiver is ready");

	// Input is refused only when the row is full and the output is stalled.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> res_valid && !res_ready)
		else $error("input refused without a stalled result");

	// A row that is full and stalled stays full at the next edge.
	a_stall_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && !res_ready |=> res_valid)
		else $error("result lost while the row was full");

endmodule

bind gost_block_cipher_ecb gbc_checker u_gbc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (data_chan.ready),
	.res_valid (result_chan.valid),
	.res_ready (result_chan.ready),
	.res_block (result_chan.out_block)
);

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the GOST 28147-89 ECB cipher top level, gost_block_cipher_ecb.
// Needs gbc_pkg and the channel interfaces in gbc_chan_if.sv; predicts each block itself.

class gost_scoreboard;
	logic [63:0] key_reg [4];
	logic [63:0] sbox_row [8];
	logic [63:0] expected_blocks [$];
	int unsigned n_blocks;
	int unsigned n_decrypt;
	int unsigned n_checked;
	int unsigned n_errors;

	// Each row packs one S-box: entry i sits in bits 4i+3:4i.
	function new(int unsigned sel);
		case (sel)
			1: begin
				sbox_row = '{64'h4D7193268EC05FAB, 64'hEB3F54C806A792D1,
					64'h6EF84957B021CDA3, 64'h6A7C324E0FD8915B,
					64'h658F4B20931DCA7E, 64'h9170A5FC8D3B264E,
					64'h1D4BC6250FA89E73, 64'h5D0CFE4A71B82369};
			end
			2: begin
				sbox_row = '{64'h1F307D8E9B5A264C, 64'hF0DB74E1C5A93286,
					64'h069C471EDAF2853B, 64'hB9E35A076F4D128C,
					64'hC24BE390D618A5F7, 64'h0E34187BAC296FD5,
					64'h73AD0B4FC19652E8, 64'h2BC96AF43850DE71};
			end
			default: begin
				sbox_row = '{64'h35F7C1B6E08D29A4, 64'h95701832AFD6C4BE,
					64'hB9067CFE243AD185, 64'h352BC64EF9801AD7,
					64'h2B30E9A48DF517C6, 64'hEFC95863D1270AB4,
					64'hC2867EA095F314BD, 64'hC8B6E3294A750DF1};
			end
		endcase
		foreach (key_reg[i]) key_reg[i] = '0;
	endfunction

	function void load_key(int unsigned idx, logic [63:0] value);
		if (idx < 4) key_reg[idx] = value;
	endfunction

	function logic [31:0] substitute_rotate(logic [31:0] x);
		logic [31:0] y;
		for (int n = 0; n < 8; n++) y[4*n +: 4] = sbox_row[n][4*x[4*n +: 4] +: 4];
		return {y[20:0], y[31:21]};
	endfunction

	function logic [63:0] cipher_block(logic dec, logic [63:0] blk);
		logic [31:0] n1;
		logic [31:0] n2;
		logic [31:0] kw;
		int unsigned k;
		n1 = blk[31:0];
		n2 = blk[63:32];
		for (int unsigned r = 0; r < 32; r++) begin
			// Decryption runs the ascending key order only in the first eight rounds.
			if ((dec == gbc_pkg::FUNC_DECRYPT) ? (r < 8) : (r < 24)) k = r % 8;
			else k = 7 - (r % 8);
			kw = key_reg[k / 2][32 * (k % 2) +: 32];
			if (r % 2 == 0) n2 ^= substitute_rotate(n1 + kw);
			else n1 ^= substitute_rotate(n2 + kw);
		end
		return {n1, n2};
	endfunction

	function void note_block(logic dec, logic [63:0] blk);
		expected_blocks.push_back(cipher_block(dec, blk));
		n_blocks++;
		if (dec == gbc_pkg::FUNC_DECRYPT) n_decrypt++;
	endfunction

	function void check_block(logic [63:0] got);
		logic [63:0] want;
		if (expected_blocks.size() == 0) begin
			n_errors++;
			$display("%0t: out_block unexpected, expected none, got %h", $time, got);
		end else begin
			want = expected_blocks.pop_front();
			n_checked++;
			if (got !== want) begin
				n_errors++;
				$display("%0t: out_block mismatch, expected %h, got %h",
					$time, want, got);
			end
		end
	endfunction

	function int unsigned outstanding();
		return expected_blocks.size();
	endfunction
endclass

module testbench;
	import gbc_pkg::*;

	localparam int unsigned SBOX_SEL = 0;
	localparam int unsigned STALL_LIMIT = 3000;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned PHASE_WORDS = 667;
	localparam logic [CFG_INDEX_W-1:0] REG_PAST_FIRST = 8'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_PAST_LAST = 8'hFF;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned idle_cycles;
	int unsigned n_key_loads;

	gbc_in_if data_if ();
	gbc_out_if result_if ();

	gost_scoreboard sb = new(SBOX_SEL);

	gost_block_cipher_ecb #(.SBOX_SELECT(SBOX_SEL)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.data_chan(data_if),
		.result_chan(result_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) sb.check_block(result_if.out_block);
	end

	// Any long stretch with no word moving on either channel means the block has hung.
	always @(posedge clk) begin
		if (!arst_n || (data_if.valid && data_if.ready) ||
				(result_if.valid && result_if.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles, %0d results outstanding",
					$time, STALL_LIMIT, sb.outstanding());
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_block(logic dec, logic [63:0] blk);
		while ($urandom_range(99) < send_idle_pct) begin
			data_if.valid <= 1'b0;
			@(negedge clk);
		end
		data_if.valid <= 1'b1;
		data_if.func <= dec;
		data_if.in_block <= blk;
		@(posedge clk);
		while (!data_if.ready) @(posedge clk);
		sb.note_block(dec, blk);
		@(negedge clk);
	endtask

	task automatic drain();
		data_if.valid <= 1'b0;
		while (sb.outstanding() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		sb.load_key(idx, value);
		@(negedge clk);
	endtask

	// The stray write goes to an index past the key registers and must change nothing.
	task automatic load_key(logic [63:0] k01, logic [63:0] k23, logic [63:0] k45,
			logic [63:0] k67, logic [CFG_INDEX_W-1:0] stray_idx);
		drain();
		write_reg(REG_KEY_01, k01);
		write_reg(REG_KEY_23, k23);
		write_reg(REG_KEY_45, k45);
		write_reg(REG_KEY_67, k67);
		write_reg(stray_idx, {$urandom, $urandom});
		cfg_we <= 1'b0;
		@(negedge clk);
		n_key_loads++;
	endtask

	task automatic run_directed();
		logic [63:0] pattern [4];
		pattern = '{64'h0, '1, 64'h0123456789ABCDEF, 64'h8000000000000001};
		foreach (pattern[i]) begin
			send_block(FUNC_ENCRYPT, pattern[i]);
			send_block(FUNC_DECRYPT, pattern[i]);
		end
	endtask

	task automatic run_random(int unsigned words);
		logic dec;
		logic [63:0] blk;
		logic last_dec;
		logic [63:0] last_out;
		last_dec = FUNC_ENCRYPT;
		last_out = '0;
		for (int unsigned i = 0; i < words; i++) begin
			if (i == words / 2) drain();
			dec = $urandom_range(1) ? FUNC_DECRYPT : FUNC_ENCRYPT;
			case ($urandom_range(9))
				// Feed the previous output back the other way, which must undo it.
				0, 1: begin
					dec = ~last_dec;
					blk = last_out;
				end
				2: blk = 64'd1 << $urandom_range(63);
				3: blk = ($urandom_range(1) ? '1 : 64'h0) ^ (64'd1 << $urandom_range(63));
				default: blk = {$urandom, $urandom};
			endcase
			send_block(dec, blk);
			last_dec = dec;
			last_out = sb.cipher_block(dec, blk);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		data_if.valid = 1'b0;
		data_if.func = FUNC_ENCRYPT;
		data_if.in_block = '0;
		result_if.ready = 1'b0;
		n_key_loads = 0;
		send_idle_pct = 37;
		recv_idle_pct = 64;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words under the reset key, then all-ones and alternating keys.
		run_directed();
		load_key('1, '1, '1, '1, REG_PAST_LAST);
		run_directed();
		load_key(64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA,
			64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA, REG_PAST_FIRST);
		run_directed();

		load_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			'1, 8'($urandom_range(4, 255)));
		run_random(PHASE_WORDS);

		send_idle_pct = 64;
		recv_idle_pct = 37;
		load_key(64'h0, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, 8'($urandom_range(4, 255)));
		run_random(PHASE_WORDS);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, 8'($urandom_range(4, 255)));
		run_random(PHASE_WORDS);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.outstanding() != 0) begin
			sb.n_errors++;
			$display("%0t: %0d expected results never arrived", $time, sb.outstanding());
		end

		$display("Ran %0d blocks (%0d decrypt) under %0d key loads plus the reset key;",
			sb.n_blocks, sb.n_decrypt, n_key_loads);
		$display("%0d results compared, %0d errors.", sb.n_checked, sb.n_errors);
		if (sb.n_errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
